[hw/rtl/lcae_pkg.sv]
// Shared constants and types for the lowest common ancestor engine.
package lcae_pkg;

  // Field widths of the stream items
  localparam int NODE_W     = 10;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 16;

  // Defaults for the top-level parameters
  localparam int MAX_NODES_DEF   = 1024;
  localparam int LIFT_LEVELS_DEF = 10;

  // Action codes carried in tuser
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ANC  = 2'd2;

  // One ancestor table entry: a valid flag and the ancestor node
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
  } entry_t;

  localparam int ENTRY_W = NODE_W + 1;

endpackage

[hw/rtl/lcae_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module lcae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word, read one word through a registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/lowest_common_ancestor_engine.sv]
// Lowest common ancestor engine on a binary-lifting ancestor table.
// Load: one table write per level, with one table read between levels while the ancestor
//   entry is valid; the table memory has a single write port.
// Query: reads both depths, then lifts through the one read port of the table memory.
// One item at a time; the next item is accepted once the result is in the output register.
// After reset a clearing pass over all MAX_NODES entries zeroes the depth memory (tready low).
module lowest_common_ancestor_engine #(
  parameter int MAX_NODES   = lcae_pkg::MAX_NODES_DEF,
  parameter int LIFT_LEVELS = lcae_pkg::LIFT_LEVELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [9:0] node_a, [19:10] node_b, [20] has_parent, [23:21] zero
  input  logic [lcae_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] action
  input  logic [lcae_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [9:0] ancestor_node, [11:10] status, [15:12] zero
  output logic [lcae_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import lcae_pkg::*;

  localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LVL_W     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int DEP_W     = LIFT_LEVELS;
  localparam int TBL_DEPTH = LIFT_LEVELS * (2 ** IDX_W);
  localparam int TA_W      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam logic [DEP_W-1:0] DEPTH_MAX = {DEP_W{1'b1}};
  localparam logic [LVL_W-1:0] LVL_LAST  = LVL_W'(LIFT_LEVELS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_NODES - 1);

  typedef enum logic [15:0] {
    S_CLR   = 16'h0001,
    S_IDLE  = 16'h0002,
    S_LDCHK = 16'h0004,
    S_LWR   = 16'h0008,
    S_LRD   = 16'h0010,
    S_QDB   = 16'h0020,
    S_QCHK  = 16'h0040,
    S_QEQ   = 16'h0080,
    S_QEQW  = 16'h0100,
    S_QSAME = 16'h0200,
    S_QJU   = 16'h0400,
    S_QJV   = 16'h0800,
    S_QJC   = 16'h1000,
    S_QFU   = 16'h2000,
    S_QFW   = 16'h4000,
    S_DONE  = 16'h8000
  } state_e;

  // Node index into the memories
  function automatic logic [IDX_W-1:0] idx(input logic [NODE_W-1:0] n);
    return IDX_W'(n);
  endfunction

  // Node lies inside the table
  function automatic logic node_inr(input logic [NODE_W-1:0] n);
    return int'(n) < MAX_NODES;
  endfunction

  // Table address of one level of one node
  function automatic logic [TA_W-1:0] taddr(input logic [LVL_W-1:0] l,
                                            input logic [NODE_W-1:0] n);
    return TA_W'({l, idx(n)});
  endfunction

  // Input item fields
  logic              in_action;
  logic [NODE_W-1:0] in_a, in_b;
  logic              in_hp;

  assign in_action = s_axis_tuser[0];
  assign in_a      = s_axis_tdata[NODE_W-1:0];
  assign in_b      = s_axis_tdata[2*NODE_W-1:NODE_W];
  assign in_hp     = s_axis_tdata[2*NODE_W];

  // Control and work registers
  state_e              state_q, state_d;
  logic [IDX_W-1:0]    clr_q, clr_d;
  logic                out_valid_q, out_valid_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [NODE_W-1:0]   a_q, a_d, b_q, b_d, u_q, u_d, v_q, v_d;
  logic [DEP_W-1:0]    diff_q, diff_d;
  logic [DEP_W:0]      da_q, da_d;
  entry_t              eu_q, eu_d, cur_q, cur_d, cur_w;
  logic                rd_pend_q, rd_pend_d;
  logic [NODE_W-1:0]   res_node_q, res_node_d, out_node_q;
  logic [STATUS_W-1:0] res_st_q, res_st_d, out_st_q;
  logic                out_load, out_free, qry_ok;
  logic [DEP_W-1:0]    dep_a, dep_b;

  // Memory ports
  logic             dep_we;
  logic [IDX_W-1:0] dep_waddr, dep_raddr;
  logic [DEP_W:0]   dep_wdata, dep_rdata;
  logic             tbl_we;
  logic [TA_W-1:0]  tbl_waddr, tbl_raddr;
  entry_t           tbl_wdata, tbl_rdata;

  // Depth memory: loaded flag on top, depth below
  lcae_ram #(
    .WIDTH (DEP_W + 1),
    .DEPTH (MAX_NODES)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  // Ancestor table: one row of nodes per lift level
  lcae_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cur_w         = rd_pend_q ? tbl_rdata : cur_q;
  assign dep_a         = da_q[DEP_W-1:0];
  assign dep_b         = dep_rdata[DEP_W-1:0];
  assign qry_ok        = node_inr(a_q) && da_q[DEP_W] && node_inr(b_q) && dep_rdata[DEP_W];

  // Sequencer over the two memories
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    lvl_d      = lvl_q;
    a_d        = a_q;
    b_d        = b_q;
    u_d        = u_q;
    v_d        = v_q;
    diff_d     = diff_q;
    da_d       = da_q;
    eu_d       = eu_q;
    cur_d      = cur_q;
    rd_pend_d  = rd_pend_q;
    res_node_d = res_node_q;
    res_st_d   = res_st_q;
    dep_we     = 1'b0;
    dep_waddr  = '0;
    dep_wdata  = '0;
    dep_raddr  = '0;
    tbl_we     = 1'b0;
    tbl_waddr  = '0;
    tbl_wdata  = '0;
    tbl_raddr  = '0;
    out_load   = 1'b0;

    unique case (state_q)
      // Sweep the depth memory to clear every loaded flag
      S_CLR: begin
        dep_we    = 1'b1;
        dep_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IDX_LAST) begin
          state_d = S_IDLE;
        end
      end

      // Take an item and start the first memory access
      S_IDLE: begin
        if (s_axis_tvalid) begin
          a_d        = in_a;
          b_d        = in_b;
          res_node_d = '0;
          res_st_d   = ST_OK;
          lvl_d      = '0;
          rd_pend_d  = 1'b0;
          if (in_action == ACT_QUERY) begin
            dep_raddr = idx(in_a);
            state_d   = S_QDB;
          end else if (!node_inr(in_a)) begin
            res_st_d = ST_MISSING;
            state_d  = S_DONE;
          end else if (!in_hp) begin
            dep_we    = 1'b1;
            dep_waddr = idx(in_a);
            dep_wdata = {1'b1, {DEP_W{1'b0}}};
            cur_d     = '0;
            state_d   = S_LWR;
          end else begin
            dep_raddr = idx(in_b);
            state_d   = S_LDCHK;
          end
        end
      end

      // Check the parent, write the child's depth
      S_LDCHK: begin
        if (!(node_inr(b_q) && dep_rdata[DEP_W])) begin
          res_st_d = ST_MISSING;
          state_d  = S_DONE;
        end else begin
          dep_we    = 1'b1;
          dep_waddr = idx(a_q);
          dep_wdata = {1'b1, (dep_b == DEPTH_MAX) ? DEPTH_MAX : dep_b + 1'b1};
          cur_d     = '{valid: 1'b1, node: b_q};
          state_d   = S_LWR;
        end
      end

      // Write one ancestor level of the loaded node
      S_LWR: begin
        tbl_we    = 1'b1;
        tbl_waddr = taddr(lvl_q, a_q);
        tbl_wdata = cur_w;
        cur_d     = cur_w;
        rd_pend_d = 1'b0;
        if (lvl_q == LVL_LAST) begin
          state_d = S_DONE;
        end else begin
          lvl_d = lvl_q + 1'b1;
          if (cur_w.valid) begin
            state_d = S_LRD;
          end
        end
      end

      // Fetch the next level from the level just below
      S_LRD: begin
        tbl_raddr = taddr(lvl_q - 1'b1, cur_q.node);
        rd_pend_d = 1'b1;
        state_d   = S_LWR;
      end

      // Hold the first depth, read the second
      S_QDB: begin
        da_d      = dep_rdata;
        dep_raddr = idx(b_q);
        state_d   = S_QCHK;
      end

      // Check both nodes, order them by depth
      S_QCHK: begin
        if (!qry_ok) begin
          res_st_d = ST_MISSING;
          state_d  = S_DONE;
        end else begin
          if (dep_a > dep_b) begin
            u_d    = b_q;
            v_d    = a_q;
            diff_d = dep_a - dep_b;
          end else begin
            u_d    = a_q;
            v_d    = b_q;
            diff_d = dep_b - dep_a;
          end
          state_d = S_QEQ;
        end
      end

      // Lift the deeper node by the set bits of the depth difference
      S_QEQ: begin
        if (diff_q[lvl_q]) begin
          tbl_raddr = taddr(lvl_q, v_q);
          state_d   = S_QEQW;
        end else if (lvl_q == LVL_LAST) begin
          state_d = S_QSAME;
        end else begin
          lvl_d = lvl_q + 1'b1;
        end
      end

      S_QEQW: begin
        if (!tbl_rdata.valid) begin
          res_st_d = ST_NO_ANC;
          state_d  = S_DONE;
        end else begin
          v_d = tbl_rdata.node;
          if (lvl_q == LVL_LAST) begin
            state_d = S_QSAME;
          end else begin
            lvl_d   = lvl_q + 1'b1;
            state_d = S_QEQ;
          end
        end
      end

      // Same node after leveling ends the query
      S_QSAME: begin
        if (u_q == v_q) begin
          res_node_d = u_q;
          state_d    = S_DONE;
        end else begin
          lvl_d   = LVL_LAST;
          state_d = S_QJU;
        end
      end

      // Joint lift from the top level down
      S_QJU: begin
        tbl_raddr = taddr(lvl_q, u_q);
        state_d   = S_QJV;
      end

      S_QJV: begin
        eu_d      = tbl_rdata;
        tbl_raddr = taddr(lvl_q, v_q);
        state_d   = S_QJC;
      end

      S_QJC: begin
        if (eu_q != tbl_rdata && eu_q.valid && tbl_rdata.valid) begin
          u_d = eu_q.node;
          v_d = tbl_rdata.node;
        end
        if (lvl_q == '0) begin
          state_d = S_QFU;
        end else begin
          lvl_d   = lvl_q - 1'b1;
          state_d = S_QJU;
        end
      end

      // Parent of the lifted node is the answer
      S_QFU: begin
        tbl_raddr = taddr('0, u_q);
        state_d   = S_QFW;
      end

      S_QFW: begin
        if (tbl_rdata.valid) begin
          res_node_d = tbl_rdata.node;
        end else begin
          res_st_d = ST_NO_ANC;
        end
        state_d = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Drop the output item once taken, raise it on a new result
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Work and result registers
  always_ff @(posedge clk_i) begin
    lvl_q      <= lvl_d;
    a_q        <= a_d;
    b_q        <= b_d;
    u_q        <= u_d;
    v_q        <= v_d;
    diff_q     <= diff_d;
    da_q       <= da_d;
    eu_q       <= eu_d;
    cur_q      <= cur_d;
    rd_pend_q  <= rd_pend_d;
    res_node_q <= res_node_d;
    res_st_q   <= res_st_d;
    if (out_load) begin
      out_node_q <= res_node_q;
      out_st_q   <= res_st_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - NODE_W - STATUS_W){1'b0}}, out_st_q, out_node_q};

endmodule
